### design/ssfs_pkg.sv
// ssfs_pkg: operation and status codes for the slot store with free stack
// no dependencies
`default_nettype none

package ssfs_pkg;

  localparam int MODE_BITS   = 2;
  localparam int INDEX_BITS  = 3;
  localparam int DATA_BITS   = 32;
  localparam int STATUS_BITS = 2;

  typedef logic [MODE_BITS-1:0]   mode_t;
  typedef logic [INDEX_BITS-1:0]  index_t;
  typedef logic [DATA_BITS-1:0]   data_t;
  typedef logic [STATUS_BITS-1:0] status_t;

  localparam mode_t MODE_PUSH = 2'd0;
  localparam mode_t MODE_POP  = 2'd1;
  localparam mode_t MODE_PEEK = 2'd2;

  localparam status_t STATUS_OK         = 2'd0;
  localparam status_t STATUS_FULL       = 2'd1;
  localparam status_t STATUS_RANGE      = 2'd2;
  localparam status_t STATUS_STACK_FULL = 2'd3;

endpackage

`default_nettype wire

### design/ssfs_ram.sv
// ssfs_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module ssfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/slot_store_with_free_stack_top.sv
// slot_store_with_free_stack_top: slot store with high-water count and free slot stack
// depends on ssfs_pkg and ssfs_ram (word store and free stack memories)
//
//  channel | ports                                  | transfer
//  --------+----------------------------------------+---------------------------
//  input   | in_mode, in_slot_index, in_value       | start high while busy low
//  result  | out_slot, out_read_word, out_status    | out_valid high, one cycle
//
// on the accept edge the ram reads are issued; the exec state then modifies
// and writes back; the registered ram read sets this
// the result shows in the cycle after the write-back and is held only that cycle
// busy is high only in the exec state, which follows each accept
// synchronous reset clears counts and slot valid bits; no clearing pass
`default_nettype none

module slot_store_with_free_stack_top #(
  parameter int SLOT_COUNT = 8,
  parameter int WORD_BITS  = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire ssfs_pkg::mode_t   in_mode,
  input  wire ssfs_pkg::index_t  in_slot_index,
  input  wire ssfs_pkg::data_t   in_value,
  output logic                   out_valid,
  output ssfs_pkg::index_t       out_slot,
  output ssfs_pkg::data_t        out_read_word,
  output ssfs_pkg::status_t      out_status
);

  import ssfs_pkg::*;

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int IW = (CW > INDEX_BITS) ? CW : INDEX_BITS;
  localparam int XW = (WORD_BITS > DATA_BITS) ? WORD_BITS : DATA_BITS;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  localparam logic [CW-1:0] SLOTS_C = CW'(SLOT_COUNT);
  localparam logic [IW-1:0] SLOTS_I = IW'(SLOT_COUNT);

  logic                  state_r, state_nxt;
  logic [CW-1:0]         used_count_r, used_count_nxt;
  logic [CW-1:0]         free_count_r, free_count_nxt;
  logic [SLOT_COUNT-1:0] valid_r, valid_nxt;
  mode_t                 mode_r;
  index_t                idx_r;
  data_t                 value_r;

  logic                  out_valid_r, out_valid_nxt;
  index_t                out_slot_r, out_slot_nxt;
  data_t                 out_read_word_r, out_read_word_nxt;
  status_t               out_status_r, out_status_nxt;

  logic                  accept;
  logic [IW-1:0]         in_idx_ext;
  logic [IW-1:0]         idx_ext;
  logic [IW-1:0]         used_ext;
  logic [IW-1:0]         s_ext;
  logic [CW-1:0]         fc_m1;
  logic [XW-1:0]         value_ext;
  logic [XW-1:0]         rword_ext;
  logic [WORD_BITS-1:0]  word_rdata;
  logic [WORD_BITS-1:0]  word_read;
  logic                  word_we;
  logic [SW-1:0]         word_waddr;
  logic [SW-1:0]         stack_rdata;
  logic                  stack_we;
  logic [SW-1:0]         s;

  assign accept     = start && (state_r == ST_IDLE);
  assign busy       = (state_r == ST_EXEC);
  assign in_idx_ext = IW'(in_slot_index);
  assign idx_ext    = IW'(idx_r);
  assign used_ext   = IW'(used_count_r);
  assign fc_m1      = free_count_r - 1'b1;
  assign value_ext  = XW'(value_r);
  assign word_read  = valid_r[idx_ext[SW-1:0]] ? word_rdata : '0;
  assign rword_ext  = XW'(word_read);
  assign s_ext      = IW'(s);

  ssfs_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (SLOT_COUNT)
  ) u_word_ram (
    .clk   (clk),
    .we    (word_we),
    .waddr (word_waddr),
    .wdata (value_ext[WORD_BITS-1:0]),
    .raddr (in_idx_ext[SW-1:0]),
    .rdata (word_rdata)
  );

  ssfs_ram #(
    .WIDTH (SW),
    .DEPTH (SLOT_COUNT)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stack_we),
    .waddr (free_count_r[SW-1:0]),
    .wdata (idx_ext[SW-1:0]),
    .raddr (fc_m1[SW-1:0]),
    .rdata (stack_rdata)
  );

  always_comb begin
    state_nxt         = state_r;
    used_count_nxt    = used_count_r;
    free_count_nxt    = free_count_r;
    valid_nxt         = valid_r;
    word_we           = 1'b0;
    stack_we          = 1'b0;
    s                 = used_count_r[SW-1:0];
    word_waddr        = s;
    out_valid_nxt     = 1'b0;
    out_slot_nxt      = '0;
    out_read_word_nxt = '0;
    out_status_nxt    = STATUS_OK;
    if (accept) begin
      state_nxt = ST_EXEC;
    end
    if (state_r == ST_EXEC) begin
      state_nxt     = ST_IDLE;
      out_valid_nxt = 1'b1;
      case (mode_r)
        MODE_PUSH: begin
          if (free_count_r != '0) begin
            s              = stack_rdata;
            word_we        = 1'b1;
            free_count_nxt = fc_m1;
            out_slot_nxt   = s_ext[INDEX_BITS-1:0];
          end else if (used_count_r >= SLOTS_C) begin
            out_status_nxt = STATUS_FULL;
          end else begin
            word_we        = 1'b1;
            used_count_nxt = used_count_r + 1'b1;
            out_slot_nxt   = s_ext[INDEX_BITS-1:0];
          end
          word_waddr = s;
          if (word_we) begin
            valid_nxt[s] = 1'b1;
          end
        end
        MODE_POP: begin
          out_slot_nxt = idx_r;
          if (idx_ext >= used_ext || idx_ext >= SLOTS_I) begin
            out_status_nxt = STATUS_RANGE;
          end else begin
            out_read_word_nxt = rword_ext[DATA_BITS-1:0];
            if (idx_ext + 1'b1 == used_ext) begin
              used_count_nxt = used_count_r - 1'b1;
            end else if (free_count_r >= SLOTS_C) begin
              out_status_nxt = STATUS_STACK_FULL;
            end else begin
              stack_we       = 1'b1;
              free_count_nxt = free_count_r + 1'b1;
            end
          end
        end
        MODE_PEEK: begin
          out_slot_nxt = idx_r;
          if (idx_ext >= SLOTS_I) begin
            out_status_nxt = STATUS_RANGE;
          end else begin
            out_read_word_nxt = rword_ext[DATA_BITS-1:0];
          end
        end
        default: begin
          out_slot_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      used_count_r <= '0;
      free_count_r <= '0;
      valid_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      used_count_r <= used_count_nxt;
      free_count_r <= free_count_nxt;
      valid_r      <= valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_mode;
      idx_r   <= in_slot_index;
      value_r <= in_value;
    end
    out_slot_r      <= out_slot_nxt;
    out_read_word_r <= out_read_word_nxt;
    out_status_r    <= out_status_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_slot      = out_slot_r;
  assign out_read_word = out_read_word_r;
  assign out_status    = out_status_r;

  // result only after a write-back cycle
  a_out_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_EXEC))
    else $error("result without write-back cycle");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_EXEC))
    else $error("accepted transfer not executed");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_count_r <= SLOTS_C)
    else $error("high-water count above capacity");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_count_r <= SLOTS_C)
    else $error("free stack count above capacity");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (word_we || stack_we) |-> (state_r == ST_EXEC))
    else $error("memory write outside write-back cycle");

endmodule

`default_nettype wire
